// ===== hw/rtl/fcd_pkg.sv =====
// ----------------------------------------------------------------------------
// fcd_pkg: shared types for the file cache directory
// Name, directory entry layout and field widths.
// ----------------------------------------------------------------------------
package fcd_pkg;

    localparam int NAME_LO_W = 64;
    localparam int NAME_HI_W = 40;
    localparam int SIZE_W    = 27;
    localparam int OFS_W     = 26;
    localparam int HITS_W    = 5;
    localparam int EVC_W     = 6;

    localparam logic [SIZE_W-1:0] STORE_MAX = 27'd67108864;

    typedef struct packed {
        logic [NAME_HI_W-1:0] hi;
        logic [NAME_LO_W-1:0] lo;
    } name_t;

    typedef struct packed {
        name_t             name;
        logic [SIZE_W-1:0] size;
        logic [OFS_W-1:0]  offset;
        logic [HITS_W-1:0] hits;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== hw/rtl/fcd_ram.sv =====
// ----------------------------------------------------------------------------
// fcd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/fcd_name_fold.sv =====
// ----------------------------------------------------------------------------
// fcd_name_fold: name normalization
// Folds lower case to upper case and zeroes everything after the first NUL.
// ----------------------------------------------------------------------------
module fcd_name_fold (
    input  fcd_pkg::name_t name_in,
    output fcd_pkg::name_t name_out
);
    import fcd_pkg::*;

    logic [103:0] raw;
    logic [103:0] folded;
    logic [12:0]  is_nul;
    logic [12:0]  ended;

    assign raw = {name_in.hi, name_in.lo};

    always_comb
    begin
        for (int i = 0; i < 13; i++)
        begin
            is_nul[i] = (raw[8*i +: 8] == 8'd0);
        end
        ended[0] = 1'b0;
        for (int i = 1; i < 13; i++)
        begin
            ended[i] = ended[i-1] | is_nul[i-1];
        end
        for (int i = 0; i < 13; i++)
        begin
            if (ended[i])
                folded[8*i +: 8] = 8'd0;
            else if (raw[8*i +: 8] >= 8'h61 && raw[8*i +: 8] <= 8'h7a)
                folded[8*i +: 8] = raw[8*i +: 8] - 8'd32;
            else
                folded[8*i +: 8] = raw[8*i +: 8];
        end
    end

    assign name_out.lo = folded[NAME_LO_W-1:0];
    assign name_out.hi = folded[103:NAME_LO_W];
endmodule

// ===== hw/rtl/file_cache_directory_lfu.sv =====
// ----------------------------------------------------------------------------
// file_cache_directory_lfu: directory of a packed blob cache, LFU eviction
// Looks up 13-character names, evicts least-hit entries and packs new blobs.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready): name_low, name_high, blob_size,
//   use_store, no_evict. One transaction in gives one transaction out
//   (out_valid/out_ready): hit, stored, offset, length, evictions.
//   The block takes one request at a time; in_ready is high only when idle.
//   Entries live in one RAM, kept packed in slots 0..count-1.
//   Every pass walks the occupied slots through the single RAM read port,
//   one slot per cycle, with the registered read data checked behind it:
//     lookup          one pass (ends early on a hit)
//     each eviction   check, victim search pass and compaction pass
//     placement       a last check, the placement, then the output load.
//   A disabled cache goes straight from acceptance to the output load.
//   If the result register still holds an untaken transaction, the block
//   waits in its final state until out_ready frees it.
//   Reset: directory empty, free space 0, caching disabled. Writing
//   store_bytes over APB (byte address 4) empties the directory at once
//   through the fill count; no clearing pass is needed. cache_enabled is
//   at byte address 0.
// ----------------------------------------------------------------------------
module file_cache_directory_lfu #(
    parameter int ENTRIES   = 32,
    parameter int HIT_LIMIT = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // APB configuration
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // request channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [fcd_pkg::NAME_LO_W-1:0] name_low,
    input  logic [fcd_pkg::NAME_HI_W-1:0] name_high,
    input  logic [fcd_pkg::SIZE_W-1:0]    blob_size,
    input  logic                      use_store,
    input  logic                      no_evict,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      hit,
    output logic                      stored,
    output logic [fcd_pkg::OFS_W-1:0]     offset,
    output logic [fcd_pkg::SIZE_W-1:0]    length,
    output logic [fcd_pkg::EVC_W-1:0]     evictions
);
    import fcd_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0]     CNT_FULL = CW'(ENTRIES);
    localparam logic [HITS_W-1:0] HLIM     = HITS_W'(HIT_LIMIT);
    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_STORE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_EVCHK, ST_SRCH, ST_COMP, ST_PLACE, ST_FIN
    } state_t;

    state_t             state_reg, state_next;
    logic               enable_reg, enable_next;
    logic [SIZE_W-1:0]  store_reg, store_next;
    logic [SIZE_W-1:0]  free_reg, free_next;
    logic [SIZE_W-1:0]  fill_reg, fill_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               pvld_reg, pvld_next;
    logic [IW-1:0]      pidx_reg, pidx_next;
    logic [IW-1:0]      victim_reg, victim_next;
    logic [HITS_W-1:0]  best_reg, best_next;
    logic [SIZE_W-1:0]  vsize_reg, vsize_next;
    // request
    name_t              rname_reg, rname_next;
    logic [SIZE_W-1:0]  rsize_reg, rsize_next;
    logic               ruse_reg, ruse_next;
    logic               rnoev_reg, rnoev_next;
    // pending result
    logic               res_hit_reg, res_hit_next;
    logic               res_st_reg, res_st_next;
    logic [OFS_W-1:0]   res_ofs_reg, res_ofs_next;
    logic [SIZE_W-1:0]  res_len_reg, res_len_next;
    logic [EVC_W-1:0]   res_evc_reg, res_evc_next;
    // output register
    logic               ovld_reg, ovld_next;
    logic               ohit_reg, ohit_next;
    logic               ost_reg, ost_next;
    logic [OFS_W-1:0]   oofs_reg, oofs_next;
    logic [SIZE_W-1:0]  olen_reg, olen_next;
    logic [EVC_W-1:0]   oevc_reg, oevc_next;

    // RAM port
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    entry_t             ram_wdata;
    logic [IW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd;
    name_t              in_name;
    name_t              fold_name;
    logic               pass_done;
    logic               cfg_wr;
    logic [HITS_W-1:0]  aged;
    logic [SIZE_W-1:0]  wr_val;

    assign rd      = entry_t'(ram_rdata);
    assign in_name = '{hi: name_high, lo: name_low};

    fcd_name_fold u_fold (
        .name_in  (in_name),
        .name_out (fold_name)
    );

    fcd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_dir (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_val = (pwdata[SIZE_W-1:0] > STORE_MAX) ? STORE_MAX : pwdata[SIZE_W-1:0];

    always_comb
    begin
        unique case (paddr[2:2])
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_STORE:  prdata = {5'd0, store_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovld_reg;
    assign hit       = ohit_reg;
    assign stored    = ost_reg;
    assign offset    = oofs_reg;
    assign length    = olen_reg;
    assign evictions = oevc_reg;

    // a scan pass is over when nothing is in flight and all slots are issued
    assign pass_done = !pvld_reg && (k_reg >= count_reg);
    assign ram_raddr = k_reg[IW-1:0];
    assign aged      = (rd.hits != '0) ? rd.hits - 1'b1 : rd.hits;

    always_comb
    begin
        state_next   = state_reg;
        enable_next  = enable_reg;
        store_next   = store_reg;
        free_next    = free_reg;
        fill_next    = fill_reg;
        count_next   = count_reg;
        k_next       = k_reg;
        pvld_next    = 1'b0;
        pidx_next    = pidx_reg;
        victim_next  = victim_reg;
        best_next    = best_reg;
        vsize_next   = vsize_reg;
        rname_next   = rname_reg;
        rsize_next   = rsize_reg;
        ruse_next    = ruse_reg;
        rnoev_next   = rnoev_reg;
        res_hit_next = res_hit_reg;
        res_st_next  = res_st_reg;
        res_ofs_next = res_ofs_reg;
        res_len_next = res_len_reg;
        res_evc_next = res_evc_reg;
        ovld_next    = ovld_reg;
        ohit_next    = ohit_reg;
        ost_next     = ost_reg;
        oofs_next    = oofs_reg;
        olen_next    = olen_reg;
        oevc_next    = oevc_reg;
        ram_we       = 1'b0;
        ram_waddr    = pidx_reg;
        ram_wdata    = rd;

        if (ovld_reg && out_ready)
            ovld_next = 1'b0;

        if (cfg_wr)
        begin
            unique case (paddr[2:2])
                REG_ENABLE: enable_next = pwdata[0];
                REG_STORE:
                begin
                    store_next = wr_val;
                    free_next  = wr_val;
                    fill_next  = '0;
                    count_next = '0;
                end
                default: ;
            endcase
        end

        // slot issue for the scanning states
        if ((state_reg == ST_LOOK || state_reg == ST_SRCH || state_reg == ST_COMP)
            && k_reg < count_reg)
        begin
            pvld_next = 1'b1;
            pidx_next = k_reg[IW-1:0];
            k_next    = k_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rname_next   = fold_name;
                    rsize_next   = blob_size;
                    ruse_next    = use_store;
                    rnoev_next   = no_evict;
                    res_hit_next = 1'b0;
                    res_st_next  = 1'b0;
                    res_ofs_next = '0;
                    res_len_next = '0;
                    res_evc_next = '0;
                    k_next       = '0;
                    state_next   = enable_reg ? ST_LOOK : ST_FIN;
                end
            end
            ST_LOOK:
            begin
                if (pvld_reg && rd.name == rname_reg)
                begin
                    ram_we       = 1'b1;
                    ram_wdata.hits = (rd.hits < HLIM) ? rd.hits + 1'b1 : rd.hits;
                    res_hit_next = 1'b1;
                    res_ofs_next = rd.offset;
                    res_len_next = rd.size;
                    pvld_next    = 1'b0;
                    state_next   = ST_FIN;
                end
                else if (pass_done)
                    state_next = ruse_reg ? ST_EVCHK : ST_FIN;
            end
            ST_EVCHK:
            begin
                k_next = '0;
                if (!rnoev_reg && free_reg < rsize_reg && count_reg != '0)
                    state_next = ST_SRCH;
                else
                    state_next = ST_PLACE;
            end
            ST_SRCH:
            begin
                if (pvld_reg && (pidx_reg == '0 || rd.hits < best_reg))
                begin
                    best_next   = rd.hits;
                    victim_next = pidx_reg;
                    vsize_next  = rd.size;
                end
                if (pass_done)
                begin
                    k_next     = '0;
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                // shift slots above the victim down one, age every count
                if (pvld_reg && pidx_reg != victim_reg)
                begin
                    ram_we         = 1'b1;
                    ram_wdata.hits = aged;
                    if (pidx_reg > victim_reg)
                    begin
                        ram_waddr        = pidx_reg - 1'b1;
                        ram_wdata.offset = rd.offset - vsize_reg[OFS_W-1:0];
                    end
                end
                if (pass_done)
                begin
                    count_next   = count_reg - 1'b1;
                    free_next    = free_reg + vsize_reg;
                    fill_next    = fill_reg - vsize_reg;
                    if (res_evc_reg != '1)
                        res_evc_next = res_evc_reg + 1'b1;
                    state_next   = ST_EVCHK;
                end
            end
            ST_PLACE:
            begin
                if (count_reg < CNT_FULL && free_reg >= rsize_reg)
                begin
                    res_st_next  = 1'b1;
                    res_ofs_next = fill_reg[OFS_W-1:0];
                    res_len_next = rsize_reg;
                    if (rsize_reg != '0)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IW-1:0];
                        ram_wdata  = '{name: rname_reg, size: rsize_reg,
                                       offset: fill_reg[OFS_W-1:0], hits: '0};
                        count_next = count_reg + 1'b1;
                        free_next  = free_reg - rsize_reg;
                        fill_next  = fill_reg + rsize_reg;
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    ohit_next  = res_hit_reg;
                    ost_next   = res_st_reg;
                    oofs_next  = res_ofs_reg;
                    olen_next  = res_len_reg;
                    oevc_next  = res_evc_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            enable_reg <= 1'b0;
            store_reg  <= '0;
            free_reg   <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            pvld_reg   <= 1'b0;
            ovld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            enable_reg <= enable_next;
            store_reg  <= store_next;
            free_reg   <= free_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            pvld_reg   <= pvld_next;
            ovld_reg   <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg    <= pidx_next;
        victim_reg  <= victim_next;
        best_reg    <= best_next;
        vsize_reg   <= vsize_next;
        rname_reg   <= rname_next;
        rsize_reg   <= rsize_next;
        ruse_reg    <= ruse_next;
        rnoev_reg   <= rnoev_next;
        res_hit_reg <= res_hit_next;
        res_st_reg  <= res_st_next;
        res_ofs_reg <= res_ofs_next;
        res_len_reg <= res_len_next;
        res_evc_reg <= res_evc_next;
        ohit_reg    <= ohit_next;
        ost_reg     <= ost_next;
        oofs_reg    <= oofs_next;
        olen_reg    <= olen_next;
        oevc_reg    <= oevc_next;
    end
endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: file cache directory with least-hit eviction
// Random and directed lookup/store requests; a behavioral directory model
// predicts every result, which is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import fcd_pkg::*;

    localparam int ENTRIES   = 32;
    localparam int HIT_LIMIT = 20;
    localparam int WDOG_MAX  = 200000;

    // register byte addresses
    localparam logic [2:0] ADDR_ENABLE = 3'd0;
    localparam logic [2:0] ADDR_STORE  = 3'd4;

    typedef struct packed {
        logic [NAME_LO_W-1:0] name_low;
        logic [NAME_HI_W-1:0] name_high;
        logic [SIZE_W-1:0]    blob_size;
        logic                 use_store;
        logic                 no_evict;
    } request_t;

    typedef struct packed {
        logic              hit;
        logic              stored;
        logic [OFS_W-1:0]  offset;
        logic [SIZE_W-1:0] length;
        logic [EVC_W-1:0]  evictions;
    } answer_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [NAME_LO_W-1:0] name_low;
    logic [NAME_HI_W-1:0] name_high;
    logic [SIZE_W-1:0]    blob_size;
    logic use_store, no_evict;
    logic hit, stored;
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] length;
    logic [EVC_W-1:0]  evictions;

    file_cache_directory_lfu dut (.*);

    // predicted directory contents
    name_t             dir_name [ENTRIES];
    logic [SIZE_W-1:0] dir_size [ENTRIES];
    logic [OFS_W-1:0]  dir_ofs  [ENTRIES];
    logic [HITS_W-1:0] dir_hits [ENTRIES];
    logic [SIZE_W-1:0] free_space, fill_ptr;
    logic              enabled;

    request_t pending_requests[$];
    answer_t  expected_answers[$];
    name_t    known_names[$];

    int errors;
    int send_idle_pct, recv_stall_pct;
    int quiet_cycles;
    bit sender_hold;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic name_t fold_name(input name_t n);
        logic [103:0] raw;
        logic [7:0]   c;
        bit           ended;
        raw = {n.hi, n.lo};
        ended = 0;
        for (int i = 0; i < 13; i++) begin
            c = raw[8*i +: 8];
            if (ended) c = 8'h00;
            else if (c == 8'h00) ended = 1;
            else if (c >= "a" && c <= "z") c = c - 8'd32;
            raw[8*i +: 8] = c;
        end
        return name_t'(raw);
    endfunction

    function automatic void clear_directory();
        for (int i = 0; i < ENTRIES; i++) begin
            dir_name[i] = '0;
            dir_size[i] = '0;
            dir_ofs[i]  = '0;
            dir_hits[i] = '0;
        end
    endfunction

    // drop the least-hit entry, compact and age; 0 when directory is empty
    function automatic bit evict_least_hit();
        int victim;
        logic [SIZE_W-1:0] sz;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_size[i] != 0 && (victim < 0 || dir_hits[i] < dir_hits[victim]))
                victim = i;
        if (victim < 0) return 0;
        sz = dir_size[victim];
        for (int i = victim; i < ENTRIES - 1; i++) begin
            dir_name[i] = dir_name[i+1];
            dir_size[i] = dir_size[i+1];
            dir_hits[i] = dir_hits[i+1];
            dir_ofs[i]  = dir_size[i] != 0 ? OFS_W'(dir_ofs[i+1] - sz) : '0;
        end
        dir_name[ENTRIES-1] = '0;
        dir_size[ENTRIES-1] = '0;
        dir_ofs[ENTRIES-1]  = '0;
        dir_hits[ENTRIES-1] = '0;
        free_space = free_space + sz;
        fill_ptr   = fill_ptr - sz;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_hits[i] > 0) dir_hits[i]--;
        return 1;
    endfunction

    function automatic answer_t serve_request(input request_t r);
        answer_t a;
        name_t   key;
        int      found, slot, evicted;
        a = '0;
        if (!enabled) return a;
        key = fold_name('{hi: r.name_high, lo: r.name_low});
        found = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && dir_size[i] != 0 && dir_name[i] == key) found = i;
        if (found >= 0) begin
            if (dir_hits[found] < HIT_LIMIT) dir_hits[found]++;
            a.hit = 1;
            a.offset = dir_ofs[found];
            a.length = dir_size[found];
            return a;
        end
        if (!r.use_store) return a;
        evicted = 0;
        if (!r.no_evict)
            while (free_space < r.blob_size && evict_least_hit()) evicted++;
        a.evictions = evicted > 63 ? 6'd63 : EVC_W'(evicted);
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && dir_size[i] == 0) slot = i;
        if (slot >= 0 && free_space >= r.blob_size) begin
            a.stored = 1;
            a.offset = fill_ptr[OFS_W-1:0];
            a.length = r.blob_size;
            if (r.blob_size != 0) begin
                dir_name[slot] = key;
                dir_size[slot] = r.blob_size;
                dir_ofs[slot]  = fill_ptr[OFS_W-1:0];
                dir_hits[slot] = '0;
                free_space = free_space - r.blob_size;
                fill_ptr   = fill_ptr + r.blob_size;
            end
        end
        return a;
    endfunction

    // driver: one request at a time from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            name_low  <= '0;
            name_high <= '0;
            blob_size <= '0;
            use_store <= 1'b0;
            no_evict  <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_answers.push_back(serve_request(pending_requests.pop_front()));
            end
            if (!(in_valid && !in_ready)) begin
                if (pending_requests.size() != 0 && !sender_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    in_valid  <= 1'b1;
                    name_low  <= pending_requests[0].name_low;
                    name_high <= pending_requests[0].name_high;
                    blob_size <= pending_requests[0].blob_size;
                    use_store <= pending_requests[0].use_store;
                    no_evict  <= pending_requests[0].no_evict;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transaction with the oldest prediction
    always @(posedge clk or negedge rst_n) begin
        answer_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            out_ready <= $urandom_range(99) >= recv_stall_pct;
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && out_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (hit != want.hit) report_mismatch("hit", hit, want.hit);
                    if (stored != want.stored)
                        report_mismatch("stored", stored, want.stored);
                    if (offset != want.offset)
                        report_mismatch("offset", offset, want.offset);
                    if (length != want.length)
                        report_mismatch("length", length, want.length);
                    if (evictions != want.evictions)
                        report_mismatch("evictions", evictions, want.evictions);
                end
            end
        end
    end

    // watchdog: nothing accepted or delivered for too long ends the run
    always @(posedge clk) begin
        if (quiet_cycles >= WDOG_MAX) begin
            $display("timeout");
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_ENABLE) begin
            enabled = data[0];
        end else begin
            clear_directory();
            free_space = data[SIZE_W-1:0] > STORE_MAX ? STORE_MAX : data[SIZE_W-1:0];
            fill_ptr = '0;
        end
    endtask

    // wait until every queued request has been answered, then let it settle
    task automatic drain();
        while (pending_requests.size() != 0 || expected_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // name built from a small pool so hits are common; random case and length
    function automatic request_t make_request(input int size_max);
        request_t r;
        name_t    n;
        int       chars;
        if (known_names.size() != 0 && $urandom_range(99) < 55) begin
            n = known_names[$urandom_range(known_names.size() - 1)];
            // lower the case of upper-case letters in the low word at random
            for (int i = 0; i < 8; i++)
                if (n.lo[8*i +: 8] >= "A" && n.lo[8*i +: 8] <= "Z" && $urandom_range(1))
                    n.lo[8*i +: 8] = n.lo[8*i +: 8] + 8'd32;
        end else if ($urandom_range(99) < 10) begin
            n.lo = {$urandom, $urandom};
            n.hi = NAME_HI_W'({$urandom, $urandom});
        end else begin
            n = '0;
            chars = $urandom_range(1, 13);
            for (int i = 0; i < chars; i++) begin
                if (i < 8) n.lo[8*i +: 8] = 8'(8'h41 + $urandom_range(5));
                else       n.hi[8*(i-8) +: 8] = 8'(8'h41 + $urandom_range(5));
            end
            if (known_names.size() < 40) known_names.push_back(n);
        end
        r.name_low  = n.lo;
        r.name_high = n.hi;
        r.blob_size = $urandom_range(99) < 5 ? SIZE_W'(0) : SIZE_W'($urandom_range(1, size_max));
        r.use_store = $urandom_range(99) < 85;
        r.no_evict  = $urandom_range(99) < 15;
        return r;
    endfunction

    task automatic run_phase(input int items, input int size_max,
                             input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) pending_requests.push_back(make_request(size_max));
        drain();
    endtask

    initial begin
        request_t r;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sender_hold = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        enabled = 0;
        clear_directory();
        free_space = '0;
        fill_ptr = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled cache: everything misses
        r = '{name_low: '1, name_high: '1, blob_size: STORE_MAX,
              use_store: 1'b1, no_evict: 1'b0};
        pending_requests.push_back(r);
        drain();

        // oversized capacity clamps; full-width fields, case folding, name end
        apb_write(ADDR_STORE, 32'h07FF_FFFF);
        apb_write(ADDR_ENABLE, 32'd1);
        pending_requests.push_back('{name_low: 64'h0000_0000_6F6C_6C65, name_high: '0,
                                     blob_size: 27'd100, use_store: 1, no_evict: 0});
        pending_requests.push_back('{name_low: 64'h0000_0000_4F4C_4C45, name_high: '0,
                                     blob_size: 27'd5, use_store: 1, no_evict: 0});
        // characters after a zero are ignored
        pending_requests.push_back('{name_low: 64'hFFFF_0000_6F6C_6C65, name_high: '1,
                                     blob_size: 27'd5, use_store: 1, no_evict: 1});
        pending_requests.push_back('{name_low: '1, name_high: '1,
                                     blob_size: STORE_MAX - 27'd100, use_store: 1, no_evict: 1});
        // zero-size blob; store refused without use_store
        pending_requests.push_back('{name_low: 64'h5A, name_high: '0,
                                     blob_size: '0, use_store: 1, no_evict: 0});
        pending_requests.push_back('{name_low: 64'h5B, name_high: '0,
                                     blob_size: 27'd1, use_store: 0, no_evict: 0});
        // eviction of everything for a max-size blob, and no_evict refusal
        pending_requests.push_back('{name_low: 64'h5C, name_high: '0,
                                     blob_size: STORE_MAX, use_store: 1, no_evict: 1});
        pending_requests.push_back('{name_low: 64'h5C, name_high: '0,
                                     blob_size: STORE_MAX, use_store: 1, no_evict: 0});
        drain();

        // empty store: eviction needed with nothing to evict
        apb_write(ADDR_STORE, 32'd10);
        pending_requests.push_back('{name_low: 64'h41, name_high: '0,
                                     blob_size: 27'd11, use_store: 1, no_evict: 0});
        // full table: 33 one-byte blobs with no eviction
        for (int i = 0; i < 2; i++) drain();
        apb_write(ADDR_STORE, 32'd1000);
        for (int i = 0; i < ENTRIES + 1; i++)
            pending_requests.push_back('{name_low: 64'h4100 + i, name_high: '0,
                                         blob_size: 27'd1, use_store: 1, no_evict: 1});
        drain();

        // random phases with different idling and capacities
        apb_write(ADDR_STORE, 32'd600);
        run_phase(500, 60, 0, 0);
        // sender hold is raised and dropped again while nothing is pending
        sender_hold = 1;
        repeat (20) @(posedge clk);
        sender_hold = 0;
        run_phase(450, 80, 76, 0);
        apb_write(ADDR_STORE, 32'd2000);
        run_phase(450, 300, 0, 76);
        apb_write(ADDR_ENABLE, 32'd0);
        run_phase(50, 50, 9, 9);
        apb_write(ADDR_ENABLE, 32'd1);
        apb_write(ADDR_STORE, 32'd0);
        run_phase(50, 20, 9, 9);
        apb_write(ADDR_STORE, 32'd150);
        run_phase(450, 40, 9, 9);

        repeat (50) @(posedge clk);
        if (errors == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/fcd_pkg.sv
hw/rtl/fcd_ram.sv
hw/rtl/fcd_name_fold.sv
hw/rtl/file_cache_directory_lfu.sv
sim/testbench.sv
